/* src/hcd_pkg.sv */
// Shared types, constants and mod-26 helpers for the 3x3 Hill decryption block.
// No dependencies; every other file in src imports this package.
`default_nettype none

package hcd_pkg;

    localparam int MOD_BASE   = 26;
    localparam int UPPER_BASE = 65;
    localparam int LOWER_BASE = 97;
    localparam int KEY_W      = 45;
    localparam int VAL_W      = 5;
    localparam int LETTER_W   = 8;
    localparam int PLAIN_W    = 7;

    typedef enum logic [2:0] {
        KI_IDLE,
        KI_ADJ,
        KI_DET,
        KI_RECIP,
        KI_INV
    } t_kinv_state;

    // Data passed from one cell of the decode chain to the next.
    typedef struct packed {
        logic                        valid;
        logic                        bad;
        logic [2:0][VAL_W-1:0]       acc;
        logic [2:0][VAL_W-1:0]       w;
    } t_cell_bus;

    // Inverse key matrix, indexed [row][col], plus status of the key unit.
    typedef struct packed {
        logic [2:0][2:0][VAL_W-1:0]  m;
        logic                        singular;
        logic                        busy;
    } t_inv_key;

    // Reduces a value below 2048 to 0..25 by conditional subtraction.
    function automatic logic [VAL_W-1:0] mod26(input logic [10:0] v);
        logic [10:0] r;
        r = v;
        if (r >= 11'(MOD_BASE * 64)) r = r - 11'(MOD_BASE * 64);
        if (r >= 11'(MOD_BASE * 32)) r = r - 11'(MOD_BASE * 32);
        if (r >= 11'(MOD_BASE * 16)) r = r - 11'(MOD_BASE * 16);
        if (r >= 11'(MOD_BASE * 8))  r = r - 11'(MOD_BASE * 8);
        if (r >= 11'(MOD_BASE * 4))  r = r - 11'(MOD_BASE * 4);
        if (r >= 11'(MOD_BASE * 2))  r = r - 11'(MOD_BASE * 2);
        if (r >= 11'(MOD_BASE))      r = r - 11'(MOD_BASE);
        return r[VAL_W-1:0];
    endfunction

    // Multiplicative inverse mod 26; zero when none exists.
    function automatic logic [VAL_W-1:0] inv26(input logic [VAL_W-1:0] a);
        logic [VAL_W-1:0] r;
        case (a)
            5'd1:    r = 5'd1;
            5'd3:    r = 5'd9;
            5'd5:    r = 5'd21;
            5'd7:    r = 5'd15;
            5'd9:    r = 5'd3;
            5'd11:   r = 5'd19;
            5'd15:   r = 5'd7;
            5'd17:   r = 5'd23;
            5'd19:   r = 5'd11;
            5'd21:   r = 5'd5;
            5'd23:   r = 5'd17;
            5'd25:   r = 5'd25;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* src/hill_cipher_3x3_decrypt_top.sv */
// Top level of the 3x3 Hill cipher decryption block (mod 26).
// Depends on hcd_pkg, hcd_keyinv and hcd_cell.
//
// Usage:
//   Configuration: write the 45-bit key on i_cfg_data with i_cfg_valid; it is taken
//   when o_cfg_ready is high. The key unit then inverts the matrix in nine adjugate
//   steps, one determinant step, one reciprocal step and nine scaling steps of a
//   shared mod-26 multiplier; meanwhile busy is high and no request is taken.
//   Requests: three ciphertext bytes are taken at an edge with start high and
//   busy low. One request may be taken every cycle.
//   Results: o_result_strobe marks one cycle with the plain letters and the two
//   flags, once the request has passed the decode register, which loads at the edge
//   that took it, then three chain cells and the output register.
//   The receiver cannot stall; results are never held.
//   A singular key or a non-letter byte gives 'A' letters and the matching flag.
//   Reset: the key clears to zero, which is singular, and the block is idle at once.
`default_nettype none

module hill_cipher_3x3_decrypt_top
    import hcd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [LETTER_W-1:0]  i_letter_first,
    input  wire logic [LETTER_W-1:0]  i_letter_second,
    input  wire logic [LETTER_W-1:0]  i_letter_third,
    input  wire logic                 i_cfg_valid,
    input  wire logic [KEY_W-1:0]     i_cfg_data,
    output logic                      o_cfg_ready,
    output logic                      o_result_strobe,
    output logic [PLAIN_W-1:0]        o_plain_first,
    output logic [PLAIN_W-1:0]        o_plain_second,
    output logic [PLAIN_W-1:0]        o_plain_third,
    output logic                      o_key_singular,
    output logic                      o_bad_letter
);

    t_inv_key                   inv_key;
    t_cell_bus                  chain [0:3];
    t_cell_bus                  r_dec, n_dec;
    logic [2:0][LETTER_W-1:0]   letters;
    logic [2:0]                 not_letter;
    logic                       r_strobe;
    logic [2:0][PLAIN_W-1:0]    r_plain, n_plain;
    logic                       r_singular, r_bad;

    hcd_keyinv u_keyinv (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_key       (inv_key)
    );

    assign busy    = inv_key.busy;
    assign letters = {i_letter_third, i_letter_second, i_letter_first};

    always_comb begin
        n_dec.valid = start && !busy;
        n_dec.acc   = '0;
        for (int n = 0; n < 3; n++) begin
            not_letter[n] = 1'b0;
            if (letters[n] >= 8'(UPPER_BASE) && letters[n] <= 8'(UPPER_BASE + 25)) begin
                n_dec.w[n] = 5'(letters[n] - 8'(UPPER_BASE));
            end else if (letters[n] >= 8'(LOWER_BASE) && letters[n] <= 8'(LOWER_BASE + 25)) begin
                n_dec.w[n] = 5'(letters[n] - 8'(LOWER_BASE));
            end else begin
                n_dec.w[n]    = '0;
                not_letter[n] = 1'b1;
            end
        end
        n_dec.bad = |not_letter;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dec.valid <= 1'b0;
        end else begin
            r_dec.valid <= n_dec.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dec.bad <= n_dec.bad;
        r_dec.acc <= n_dec.acc;
        r_dec.w   <= n_dec.w;
    end

    assign chain[0] = r_dec;

    // Cell g folds in column g of the inverse key against letter g.
    for (genvar g = 0; g < 3; g++) begin : g_cells
        logic [2:0][VAL_W-1:0] col;
        always_comb begin
            for (int i = 0; i < 3; i++) begin
                col[i] = inv_key.m[i][g];
            end
        end
        hcd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_bus   (chain[g]),
            .i_col   (col),
            .o_bus   (chain[g+1])
        );
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (inv_key.singular || chain[3].bad) begin
                n_plain[i] = 7'(UPPER_BASE);
            end else begin
                n_plain[i] = 7'(UPPER_BASE) + 7'(chain[3].acc[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= chain[3].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_plain    <= n_plain;
        r_singular <= inv_key.singular;
        r_bad      <= chain[3].bad;
    end

    assign o_result_strobe = r_strobe;
    assign o_plain_first   = r_plain[0];
    assign o_plain_second  = r_plain[1];
    assign o_plain_third   = r_plain[2];
    assign o_key_singular  = r_singular;
    assign o_bad_letter    = r_bad;

endmodule

`default_nettype wire

/* src/hcd_keyinv.sv */
// Key register and sequential mod-26 inversion of the 3x3 key matrix.
// Depends on hcd_pkg for types, the state enum and the mod-26 helpers.
`default_nettype none

module hcd_keyinv
    import hcd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_valid,
    input  wire logic [KEY_W-1:0]   i_cfg_data,
    output logic                    o_cfg_ready,
    output t_inv_key                o_key
);

    localparam logic [10:0] ADJ_BIAS = 11'(MOD_BASE * MOD_BASE);

    t_kinv_state                  r_state, n_state;
    logic [3:0]                   r_step, n_step;
    logic [1:0]                   r_jcnt, n_jcnt;
    logic [2:0][2:0][VAL_W-1:0]   r_key, n_key;
    logic [8:0][VAL_W-1:0]        r_sr, n_sr;
    logic [VAL_W-1:0]             r_det, n_det;
    logic [VAL_W-1:0]             r_dinv, n_dinv;

    logic [9:0]                   prod_a, prod_b, prod_inv;
    logic [9:0]                   det_p0, det_p1, det_p2;
    logic [VAL_W-1:0]             adj_val, inv_val, det_val, load_v;
    logic                         cfg_wr;

    assign cfg_wr = i_cfg_valid && o_cfg_ready;

    // The key is kept rotated so each adjugate term is read at fixed places:
    // rows turn every step, columns every third step.
    assign prod_a   = 10'(r_key[1][1]) * 10'(r_key[2][2]);
    assign prod_b   = 10'(r_key[1][2]) * 10'(r_key[2][1]);
    assign adj_val  = mod26(11'(prod_a) + ADJ_BIAS - 11'(prod_b));
    assign prod_inv = 10'(r_sr[0]) * 10'(r_dinv);
    assign inv_val  = mod26(11'(prod_inv));
    assign det_p0   = 10'(r_key[0][0]) * 10'(r_sr[0]);
    assign det_p1   = 10'(r_key[0][1]) * 10'(r_sr[3]);
    assign det_p2   = 10'(r_key[0][2]) * 10'(r_sr[6]);
    assign det_val  = mod26(11'(det_p0) + 11'(det_p1) + 11'(det_p2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= KI_IDLE;
            r_step  <= '0;
            r_jcnt  <= '0;
            r_key   <= '0;
            r_dinv  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_jcnt  <= n_jcnt;
            r_key   <= n_key;
            r_dinv  <= n_dinv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sr  <= n_sr;
        r_det <= n_det;
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_jcnt  = r_jcnt;
        n_key   = r_key;
        n_sr    = r_sr;
        n_det   = r_det;
        n_dinv  = r_dinv;
        load_v  = '0;
        case (r_state)
            KI_IDLE: begin
                if (cfg_wr) begin
                    for (int e = 0; e < 9; e++) begin
                        load_v = i_cfg_data[VAL_W*e +: VAL_W];
                        if (load_v >= 5'(MOD_BASE)) load_v = load_v - 5'(MOD_BASE);
                        n_key[e/3][e%3] = load_v;
                    end
                    n_step  = '0;
                    n_jcnt  = '0;
                    n_state = KI_ADJ;
                end
            end
            KI_ADJ: begin
                n_sr = {adj_val, r_sr[8:1]};
                for (int r = 0; r < 3; r++) begin
                    for (int c = 0; c < 3; c++) begin
                        if (r_jcnt == 2'd2) n_key[r][c] = r_key[(r+1)%3][(c+1)%3];
                        else                n_key[r][c] = r_key[(r+1)%3][c];
                    end
                end
                n_jcnt = (r_jcnt == 2'd2) ? 2'd0 : r_jcnt + 2'd1;
                if (r_step == 4'd8) begin
                    n_step  = '0;
                    n_state = KI_DET;
                end else begin
                    n_step = r_step + 4'd1;
                end
            end
            KI_DET: begin
                n_det   = det_val;
                n_state = KI_RECIP;
            end
            KI_RECIP: begin
                n_dinv  = inv26(r_det);
                n_state = KI_INV;
            end
            KI_INV: begin
                n_sr = {inv_val, r_sr[8:1]};
                if (r_step == 4'd8) begin
                    n_step  = '0;
                    n_state = KI_IDLE;
                end else begin
                    n_step = r_step + 4'd1;
                end
            end
            default: begin
                n_state = KI_IDLE;
            end
        endcase
    end

    assign o_cfg_ready = (r_state == KI_IDLE);

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                o_key.m[r][c] = r_sr[r*3 + c];
            end
        end
        o_key.singular = (r_dinv == '0);
        o_key.busy     = (r_state != KI_IDLE);
    end

    a_cfg_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr |=> (r_state == KI_ADJ) && (r_step == 4'd0))
        else $error("config write did not start key inversion");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step <= 4'd8) && (r_jcnt <= 2'd2))
        else $error("sequencer counter out of range");

    a_inv_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == KI_INV) && (r_step == 4'd8) |=> (r_state == KI_IDLE))
        else $error("inversion did not return to idle");

    a_adj_to_det: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == KI_ADJ) && (r_step == 4'd8) |=> (r_state == KI_DET) && (r_jcnt == 2'd0))
        else $error("adjugate pass left the key rotated");

endmodule

`default_nettype wire

/* src/hcd_cell.sv */
// One cell of the decode chain: adds one key column times one letter, mod 26.
// Depends on hcd_pkg for the cell bus type and the mod-26 helper.
`default_nettype none

module hcd_cell
    import hcd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cell_bus             i_bus,
    input  wire logic [2:0][VAL_W-1:0] i_col,
    output t_cell_bus                  o_bus
);

    t_cell_bus         r_bus, n_bus;
    logic [2:0][9:0]   prod;

    always_comb begin
        n_bus = i_bus;
        for (int i = 0; i < 3; i++) begin
            prod[i]      = 10'(i_col[i]) * 10'(i_bus.w[0]);
            n_bus.acc[i] = mod26(11'(i_bus.acc[i]) + 11'(prod[i]));
        end
        // The letter used here is dropped; the next cell sees the following one first.
        n_bus.w = {{VAL_W{1'b0}}, i_bus.w[2], i_bus.w[1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus.valid <= 1'b0;
        end else begin
            r_bus.valid <= n_bus.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bus.bad <= n_bus.bad;
        r_bus.acc <= n_bus.acc;
        r_bus.w   <= n_bus.w;
    end

    assign o_bus = r_bus;

endmodule

`default_nettype wire
